### hdl/avpid_pkg.sv
// Shared types, constants and register map for the altitude/velocity PID block.
package avpid_pkg;

  // Limits and fixed offsets of the control law
  localparam int TILT_LIMIT    = 800;      // decidegrees, tilt cutoff
  localparam int HOLD_OFFSET   = 20;       // cm above estimate while disarmed
  localparam int HOLD_MAX      = 131071;   // hold target saturation
  localparam int ALT_ERR_LIMIT = 500;      // cm
  localparam int REACH_BAND    = 5;        // cm
  localparam int SETV_MAX      = 50;       // cm/s, highest climb setpoint
  localparam int P_LIMIT       = 300;
  localparam int I_LIMIT       = 8192 * 300;
  localparam int I_SHIFT       = 13;       // integrator / 8192
  localparam int D_LIMIT       = 150;

  localparam int PROD_W = 26;              // 9b signed gain x 17b signed operand

  // Register reset values
  localparam logic [7:0]        ALT_P_GAIN_RST    = 8'd50;
  localparam logic [7:0]        VEL_P_GAIN_RST    = 8'd120;
  localparam logic [7:0]        VEL_I_GAIN_RST    = 8'd45;
  localparam logic [7:0]        VEL_D_GAIN_RST    = 8'd1;
  localparam logic [6:0]        ALT_DEADBAND_RST  = 7'd5;
  localparam logic signed [9:0] DESCENT_LIMIT_RST = -10'sd50;

  typedef enum logic [2:0] {
    REG_ALT_P_GAIN    = 3'd0,
    REG_VEL_P_GAIN    = 3'd1,
    REG_VEL_I_GAIN    = 3'd2,
    REG_VEL_D_GAIN    = 3'd3,
    REG_ALT_DEADBAND  = 3'd4,
    REG_DESCENT_LIMIT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]        alt_p_gain;
    logic [7:0]        vel_p_gain;
    logic [7:0]        vel_i_gain;
    logic [7:0]        vel_d_gain;
    logic [6:0]        alt_deadband;
    logic signed [9:0] descent_limit;
  } cfg_t;

  // Post-multiply scaling, truncating toward zero
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_5    = 2'd1,
    SHIFT_7    = 2'd2,
    SHIFT_9    = 2'd3
  } shift_e;

  typedef struct packed {
    logic [7:0]         gain;
    logic signed [16:0] operand;
    shift_e             shift;
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_ALT,
    ST_VERR,
    ST_PTERM,
    ST_ITERM,
    ST_DTERM,
    ST_FIN
  } state_e;

endpackage

### hdl/avpid_if.sv
// Valid/ready channel interfaces for control-tick inputs and results.
interface avpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] est_altitude;
  logic signed [15:0] vertical_velocity;
  logic signed [15:0] accel_z;
  logic signed [11:0] roll_tilt;
  logic signed [11:0] pitch_tilt;
  logic               armed;
  logic               auto_mode;
  logic signed [17:0] desired_height;
  logic signed [17:0] target_altitude;
  logic               velocity_mode;
  logic signed [9:0]  commanded_velocity;

  modport source (
    output valid, est_altitude, vertical_velocity, accel_z, roll_tilt, pitch_tilt,
           armed, auto_mode, desired_height, target_altitude, velocity_mode,
           commanded_velocity,
    input  ready
  );
  modport sink (
    input  valid, est_altitude, vertical_velocity, accel_z, roll_tilt, pitch_tilt,
           armed, auto_mode, desired_height, target_altitude, velocity_mode,
           commanded_velocity,
    output ready
  );
endinterface

interface avpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] throttle_adjust;
  logic               height_reached;
  logic signed [17:0] hold_altitude;

  modport source (
    output valid, throttle_adjust, height_reached, hold_altitude,
    input  ready
  );
  modport sink (
    input  valid, throttle_adjust, height_reached, hold_altitude,
    output ready
  );
endinterface

### hdl/avpid_cfg_regs.sv
// APB configuration registers for gains, deadband and descent limit.
module avpid_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output avpid_pkg::cfg_t     cfg_o
);

  avpid_pkg::cfg_t      cfg_q;
  avpid_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = avpid_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt_p_gain    <= avpid_pkg::ALT_P_GAIN_RST;
      cfg_q.vel_p_gain    <= avpid_pkg::VEL_P_GAIN_RST;
      cfg_q.vel_i_gain    <= avpid_pkg::VEL_I_GAIN_RST;
      cfg_q.vel_d_gain    <= avpid_pkg::VEL_D_GAIN_RST;
      cfg_q.alt_deadband  <= avpid_pkg::ALT_DEADBAND_RST;
      cfg_q.descent_limit <= avpid_pkg::DESCENT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        avpid_pkg::REG_ALT_P_GAIN:    cfg_q.alt_p_gain    <= pwdata[7:0];
        avpid_pkg::REG_VEL_P_GAIN:    cfg_q.vel_p_gain    <= pwdata[7:0];
        avpid_pkg::REG_VEL_I_GAIN:    cfg_q.vel_i_gain    <= pwdata[7:0];
        avpid_pkg::REG_VEL_D_GAIN:    cfg_q.vel_d_gain    <= pwdata[7:0];
        avpid_pkg::REG_ALT_DEADBAND:  cfg_q.alt_deadband  <= pwdata[6:0];
        avpid_pkg::REG_DESCENT_LIMIT: cfg_q.descent_limit <= signed'(pwdata[9:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      avpid_pkg::REG_ALT_P_GAIN:    prdata = {24'd0, cfg_q.alt_p_gain};
      avpid_pkg::REG_VEL_P_GAIN:    prdata = {24'd0, cfg_q.vel_p_gain};
      avpid_pkg::REG_VEL_I_GAIN:    prdata = {24'd0, cfg_q.vel_i_gain};
      avpid_pkg::REG_VEL_D_GAIN:    prdata = {24'd0, cfg_q.vel_d_gain};
      avpid_pkg::REG_ALT_DEADBAND:  prdata = {25'd0, cfg_q.alt_deadband};
      avpid_pkg::REG_DESCENT_LIMIT: prdata = 32'(cfg_q.descent_limit);
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

### hdl/avpid_mul_unit.sv
// Shared gain multiplier with truncating power-of-two scale, result registered.
module avpid_mul_unit (
  input  logic                                  clk_i,
  input  avpid_pkg::mul_op_t                    op_i,
  output logic signed [avpid_pkg::PROD_W-1:0]   result_o
);

  logic signed [8:0]                    gain_s;
  logic signed [avpid_pkg::PROD_W-1:0]  prod;
  logic signed [avpid_pkg::PROD_W-1:0]  bias;
  logic signed [avpid_pkg::PROD_W-1:0]  biased;
  logic signed [avpid_pkg::PROD_W-1:0]  scaled;
  logic signed [avpid_pkg::PROD_W-1:0]  result_q;

  assign gain_s = signed'({1'b0, op_i.gain});
  assign prod   = avpid_pkg::PROD_W'(gain_s) * avpid_pkg::PROD_W'(op_i.operand);

  // negative products get 2^k-1 added so the shift rounds toward zero
  always_comb begin
    bias = '0;
    case (op_i.shift)
      avpid_pkg::SHIFT_5: bias = avpid_pkg::PROD_W'(31);
      avpid_pkg::SHIFT_7: bias = avpid_pkg::PROD_W'(127);
      avpid_pkg::SHIFT_9: bias = avpid_pkg::PROD_W'(511);
      default:            bias = '0;
    endcase
    biased = prod + (prod[avpid_pkg::PROD_W-1] ? bias : '0);
    case (op_i.shift)
      avpid_pkg::SHIFT_5: scaled = biased >>> 5;
      avpid_pkg::SHIFT_7: scaled = biased >>> 7;
      avpid_pkg::SHIFT_9: scaled = biased >>> 9;
      default:            scaled = biased;
    endcase
  end

  always_ff @(posedge clk_i) begin
    result_q <= scaled;
  end

  assign result_o = result_q;

endmodule

### hdl/altitude_velocity_pid.sv
// Top level: cascaded altitude-hold / velocity PID controller with sequencer.
// One input transaction is one control tick: the block latches the estimate,
// attitude, flags and commands, then a small sequencer walks the tick through
// one shared gain multiplier (altitude P, velocity P, velocity I, accel D, in
// that order, each product registered before use). The result is loaded into
// the output register after these sequencer steps, in order: the altitude error
// stage, the altitude multiply, the velocity error stage, the P, I and D
// multiplies and the final sum. in_if.ready is high only while the sequencer
// is idle, so a new tick is accepted only once the previous one has passed
// the seven sequencer steps and returned to idle. The result sits in an
// output register; the next tick is accepted while it waits, and a tick only
// stalls at its last step if the previous result still has not been taken.
// If roll or pitch reaches 80 deg, throttle_adjust is 0, the integrator holds
// and hold_altitude is the target input. Disarmed ticks clear the integrator
// and derive the hold target from the estimate (+20 cm) or from desired_height
// in auto mode. Gains, deadband and descent limit sit on the APB port at byte
// address 4*index and should be written only while the block is idle.
module altitude_velocity_pid (
  input  logic            clk_i,
  input  logic            rst_ni,
  avpid_in_if.sink        in_if,
  avpid_out_if.source     out_if,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int PW = avpid_pkg::PROD_W;

  avpid_pkg::cfg_t     cfg;
  avpid_pkg::state_e   state_q, state_d;
  avpid_pkg::mul_op_t  mul_op;
  logic signed [PW-1:0] mul_res;

  // latched tick inputs
  logic signed [17:0] est_q, desired_q, target_q;
  logic signed [15:0] vel_q, acc_q;
  logic signed [9:0]  cmdvel_q;
  logic               tilt_ok_q, armed_q, auto_q, velmode_q;

  // intermediate terms
  logic signed [17:0] hold_q;
  logic signed [9:0]  alt_err_q;
  logic               reach_q;
  logic signed [16:0] vel_err_q, acc_sum_q;
  logic signed [9:0]  p_q;

  // persistent state
  logic signed [22:0] integ_q;
  logic signed [15:0] prev_accel_q;
  logic               reached_flag_q;

  // output register
  logic               out_valid_q;
  logic signed [10:0] out_adj_q;
  logic               out_reached_q;
  logic signed [17:0] out_hold_q;

  logic               accept, fin_go;

  avpid_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  avpid_mul_unit u_mul (
    .clk_i    (clk_i),
    .op_i     (mul_op),
    .result_o (mul_res)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= avpid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    mul_op.gain    = '0;
    mul_op.operand = '0;
    mul_op.shift   = avpid_pkg::SHIFT_NONE;
    in_if.ready   = 1'b0;
    unique case (state_q)
      avpid_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) state_d = avpid_pkg::ST_ERR;
      end
      avpid_pkg::ST_ERR: state_d = avpid_pkg::ST_ALT;
      avpid_pkg::ST_ALT: begin
        mul_op.gain    = cfg.alt_p_gain;
        mul_op.operand = 17'(alt_err_q);
        mul_op.shift   = avpid_pkg::SHIFT_7;
        state_d        = avpid_pkg::ST_VERR;
      end
      avpid_pkg::ST_VERR: state_d = avpid_pkg::ST_PTERM;
      avpid_pkg::ST_PTERM: begin
        mul_op.gain    = cfg.vel_p_gain;
        mul_op.operand = vel_err_q;
        mul_op.shift   = avpid_pkg::SHIFT_5;
        state_d        = avpid_pkg::ST_ITERM;
      end
      avpid_pkg::ST_ITERM: begin
        mul_op.gain    = cfg.vel_i_gain;
        mul_op.operand = vel_err_q;
        mul_op.shift   = avpid_pkg::SHIFT_NONE;
        state_d        = avpid_pkg::ST_DTERM;
      end
      avpid_pkg::ST_DTERM: begin
        mul_op.gain    = cfg.vel_d_gain;
        mul_op.operand = acc_sum_q;
        mul_op.shift   = avpid_pkg::SHIFT_9;
        state_d        = avpid_pkg::ST_FIN;
      end
      avpid_pkg::ST_FIN: begin
        // keep the D operands so the damping product holds while stalled
        mul_op.gain    = cfg.vel_d_gain;
        mul_op.operand = acc_sum_q;
        mul_op.shift   = avpid_pkg::SHIFT_9;
        if (!out_valid_q || out_if.ready) state_d = avpid_pkg::ST_IDLE;
      end
      default: state_d = avpid_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_if.valid && in_if.ready;
  assign fin_go = (state_q == avpid_pkg::ST_FIN) && (!out_valid_q || out_if.ready);

  // ---------------------------------------------------------------------
  // Altitude error stage
  // ---------------------------------------------------------------------
  logic signed [18:0] est_ext, est_plus, alt_diff;
  logic signed [17:0] hold_sel;
  logic signed [9:0]  alt_clamp, db_s, alt_err_d;
  logic [9:0]         alt_mag, db_u;

  always_comb begin
    est_ext  = 19'(est_q);
    est_plus = est_ext + 19'(avpid_pkg::HOLD_OFFSET);
    hold_sel = target_q;
    if (tilt_ok_q && !armed_q) begin
      if (auto_q) begin
        hold_sel = desired_q;
      end else if (est_plus > 19'(avpid_pkg::HOLD_MAX)) begin
        hold_sel = 18'(avpid_pkg::HOLD_MAX);
      end else begin
        hold_sel = est_plus[17:0];
      end
    end
    alt_diff = 19'(hold_sel) - est_ext;
    if (alt_diff > 19'(avpid_pkg::ALT_ERR_LIMIT)) begin
      alt_clamp = 10'(avpid_pkg::ALT_ERR_LIMIT);
    end else if (alt_diff < -19'(avpid_pkg::ALT_ERR_LIMIT)) begin
      alt_clamp = -10'(avpid_pkg::ALT_ERR_LIMIT);
    end else begin
      alt_clamp = alt_diff[9:0];
    end
    alt_mag = alt_clamp[9] ? 10'(-alt_clamp) : 10'(alt_clamp);
    db_u    = {3'd0, cfg.alt_deadband};
    db_s    = signed'(db_u);
    if (alt_mag < db_u) begin
      alt_err_d = '0;
    end else if (!alt_clamp[9]) begin
      alt_err_d = alt_clamp - db_s;
    end else begin
      alt_err_d = alt_clamp + db_s;
    end
  end

  // ---------------------------------------------------------------------
  // Velocity setpoint, P/I/D terms and final sum
  // ---------------------------------------------------------------------
  logic signed [9:0]  alt_setv, setv;
  logic signed [26:0] integ_sum;
  logic signed [22:0] integ_d;
  logic signed [23:0] integ_bias;
  logic signed [10:0] i_term;
  logic signed [8:0]  d_term;
  logic signed [11:0] adj_sum;
  logic signed [10:0] adj;
  logic signed [9:0]  p_d;

  always_comb begin
    // altitude loop output; lower bound checked first so it wins
    if (mul_res < PW'(cfg.descent_limit)) begin
      alt_setv = cfg.descent_limit;
    end else if (mul_res > PW'(avpid_pkg::SETV_MAX)) begin
      alt_setv = 10'(avpid_pkg::SETV_MAX);
    end else begin
      alt_setv = mul_res[9:0];
    end
    setv = velmode_q ? cmdvel_q : alt_setv;

    if (mul_res > PW'(avpid_pkg::P_LIMIT)) begin
      p_d = 10'(avpid_pkg::P_LIMIT);
    end else if (mul_res < -PW'(avpid_pkg::P_LIMIT)) begin
      p_d = -10'(avpid_pkg::P_LIMIT);
    end else begin
      p_d = mul_res[9:0];
    end

    integ_sum = 27'(integ_q) + 27'(mul_res);
    if (!armed_q) begin
      integ_d = '0;
    end else if (integ_sum > 27'(avpid_pkg::I_LIMIT)) begin
      integ_d = 23'(avpid_pkg::I_LIMIT);
    end else if (integ_sum < -27'(avpid_pkg::I_LIMIT)) begin
      integ_d = -23'(avpid_pkg::I_LIMIT);
    end else begin
      integ_d = integ_sum[22:0];
    end

    if (mul_res > PW'(avpid_pkg::D_LIMIT)) begin
      d_term = 9'(avpid_pkg::D_LIMIT);
    end else if (mul_res < -PW'(avpid_pkg::D_LIMIT)) begin
      d_term = -9'(avpid_pkg::D_LIMIT);
    end else begin
      d_term = mul_res[8:0];
    end

    // integrator / 8192, toward zero
    integ_bias = 24'(integ_q) + (integ_q[22] ? 24'sd8191 : 24'sd0);
    i_term     = 11'(integ_bias >>> avpid_pkg::I_SHIFT);
    adj_sum    = 12'(p_q) + 12'(i_term) - 12'(d_term);
    adj        = tilt_ok_q ? adj_sum[10:0] : '0;
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      est_q     <= in_if.est_altitude;
      vel_q     <= in_if.vertical_velocity;
      acc_q     <= in_if.accel_z;
      tilt_ok_q <= (in_if.roll_tilt  < 12'(avpid_pkg::TILT_LIMIT)) &&
                   (in_if.roll_tilt  > -12'(avpid_pkg::TILT_LIMIT)) &&
                   (in_if.pitch_tilt < 12'(avpid_pkg::TILT_LIMIT)) &&
                   (in_if.pitch_tilt > -12'(avpid_pkg::TILT_LIMIT));
      armed_q   <= in_if.armed;
      auto_q    <= in_if.auto_mode;
      desired_q <= in_if.desired_height;
      target_q  <= in_if.target_altitude;
      velmode_q <= in_if.velocity_mode;
      cmdvel_q  <= in_if.commanded_velocity;
    end
    if (state_q == avpid_pkg::ST_ERR) begin
      hold_q    <= hold_sel;
      alt_err_q <= alt_err_d;
      // |err| < 5 after the deadband
      reach_q   <= (alt_mag < db_u) || ((alt_mag - db_u) < 10'(avpid_pkg::REACH_BAND));
    end
    if (state_q == avpid_pkg::ST_VERR) begin
      vel_err_q <= 17'(setv) - 17'(vel_q);
      acc_sum_q <= 17'(acc_q) + 17'(prev_accel_q);
    end
    if (state_q == avpid_pkg::ST_ITERM) begin
      p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q        <= '0;
      prev_accel_q   <= '0;
      reached_flag_q <= 1'b0;
    end else begin
      if (state_q == avpid_pkg::ST_DTERM && tilt_ok_q) begin
        integ_q <= integ_d;
      end
      if (fin_go) begin
        prev_accel_q <= acc_q;
        if (tilt_ok_q && !velmode_q) reached_flag_q <= reach_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_adj_q     <= adj;
      out_reached_q <= (tilt_ok_q && !velmode_q) ? reach_q : reached_flag_q;
      out_hold_q    <= hold_q;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.throttle_adjust = out_adj_q;
  assign out_if.height_reached  = out_reached_q;
  assign out_if.hold_altitude   = out_hold_q;

endmodule
